>>> hdl/cuckoo_filter_engine_macros.svh
// Assertion helpers shared by the cuckoo filter engine modules.
`ifndef CUCKOO_FILTER_ENGINE_MACROS_SVH
`define CUCKOO_FILTER_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define CFE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define CFE_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);

`else

`define CFE_ASSERT(lbl, clk, rstn, prop, msg)
`define CFE_ASSERT_NEVER(lbl, clk, rstn, prop, msg)

`endif

`endif

>>> hdl/cfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfe_pkg;

  // Field widths of the request and response channels
  localparam int unsigned OP_W   = 2;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 13;

  // Fingerprint and key geometry
  localparam int unsigned TAG_W         = 8;
  localparam int unsigned MAX_KEY_BYTES = 8;

  // Hash and slot chooser constants
  localparam logic [31:0] HASH_SEED = 32'hbc9f1d34;
  localparam logic [31:0] HASH_MUL  = 32'h5bd1e995;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] LFSR_SEED = 16'hACE1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_QUERY  = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // Classified request handed from the hash front end to the table engine
  typedef struct packed {
    op_e              op;
    logic [TAG_W-1:0] tag;
  } cmd_t;

  // One MurmurHash2 multiply step, modulo 2^32
  function automatic logic [31:0] hash_mul(input logic [31:0] a);
    return a * HASH_MUL;
  endfunction

  // Fingerprint scramble used for the alternate bucket
  function automatic logic [31:0] tag_mix(input logic [TAG_W-1:0] t);
    return 32'(t) * HASH_MUL;
  endfunction

endpackage

`default_nettype wire

>>> hdl/cfe_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one filter operation on one key
interface cfe_req_if;
  logic                           valid;
  logic                           ready;
  logic [cfe_pkg::OP_W-1:0]       operation;
  logic [cfe_pkg::KEY_W-1:0]      key_bytes;
  logic [cfe_pkg::LEN_W-1:0]      key_length;

  modport source (output valid, operation, key_bytes, key_length, input ready);
  modport sink   (input valid, operation, key_bytes, key_length, output ready);
endinterface

// Response channel: outcome of one request
interface cfe_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [cfe_pkg::STAT_W-1:0]     status;
  logic [cfe_pkg::CNT_W-1:0]      item_count;
  logic                           victim_in_use;

  modport source (output valid, status, item_count, victim_in_use, input ready);
  modport sink   (input valid, status, item_count, victim_in_use, output ready);
endinterface

`default_nettype wire

>>> hdl/cfe_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module cfe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/cfe_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

`include "cuckoo_filter_engine_macros.svh"

module cfe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output      logic             push_ready_o,
  input  wire logic [WIDTH-1:0] push_data_i,
  output      logic             pop_valid_o,
  input  wire logic             pop_ready_i,
  output      logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push) begin
      wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
    end
    if (pop) begin
      rp_d = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

  `CFE_ASSERT(a_fifo_bound, clk_i, rst_ni, cnt_q <= CW'(DEPTH), "queue occupancy above depth")
  `CFE_ASSERT(a_fifo_ptrs, clk_i, rst_ni, (cnt_q == '0) |-> (wp_q == rp_q), "empty queue with split pointers")
  `CFE_ASSERT(a_fifo_cnt, clk_i, rst_ni, (push && !pop) |=> (cnt_q == $past(cnt_q) + CW'(1)), "push lost")

endmodule

`default_nettype wire

>>> hdl/cfe_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cfe_front #(
  parameter int unsigned BW = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  cfe_req_if.sink                            req_i,
  output      logic                          cmd_valid_o,
  input  wire logic                          cmd_ready_i,
  output      cfe_pkg::cmd_t                 cmd_o,
  output      logic [BW-1:0]                 b1_o,
  output      logic [BW-1:0]                 b2_o
);

  localparam int unsigned TW = cfe_pkg::TAG_W;
  localparam int unsigned LW = cfe_pkg::LEN_W;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_K1   = 3'd1;
  localparam logic [2:0] F_K2   = 3'd2;
  localparam logic [2:0] F_H    = 3'd3;
  localparam logic [2:0] F_TAIL = 3'd4;
  localparam logic [2:0] F_FIN1 = 3'd5;
  localparam logic [2:0] F_FIN2 = 3'd6;
  localparam logic [2:0] F_PUSH = 3'd7;

  logic [2:0]                state_q, state_d;
  cfe_pkg::op_e              op_q, op_d;
  logic [cfe_pkg::KEY_W-1:0] key_q, key_d;
  logic [LW-1:0]             rest_q, rest_d;
  logic                      pos_q, pos_d;
  logic [31:0]               h_q, h_d, k_q, k_d;
  logic [BW-1:0]             b1_q, b1_d;
  logic [TW-1:0]             tag_q, tag_d;
  logic [31:0]               word, tail, h_fin, mix;
  logic [LW-1:0]             len_sat;

  // Pick the next hash step from the number of bytes still to fold in
  function automatic logic [2:0] next_step(input logic [LW-1:0] rest);
    if (rest >= LW'(4)) begin
      return F_K1;
    end else if (rest != '0) begin
      return F_TAIL;
    end
    return F_FIN1;
  endfunction

  assign word    = pos_q ? key_q[63:32] : key_q[31:0];
  assign len_sat = (req_i.key_length > LW'(cfe_pkg::MAX_KEY_BYTES)) ?
                   LW'(cfe_pkg::MAX_KEY_BYTES) : req_i.key_length;
  assign h_fin   = h_q ^ (h_q >> 15);
  assign mix     = cfe_pkg::tag_mix(tag_q);

  assign req_i.ready = (state_q == F_IDLE);
  assign cmd_valid_o = (state_q == F_PUSH);
  assign cmd_o.op    = op_q;
  assign cmd_o.tag   = tag_q;
  assign b1_o        = b1_q;
  assign b2_o        = b1_q ^ mix[BW-1:0];

  // Fold the trailing bytes of the key
  always_comb begin
    tail = h_q;
    if (rest_q >= LW'(3)) begin
      tail = tail ^ {8'h00, word[23:16], 16'h0000};
    end
    if (rest_q >= LW'(2)) begin
      tail = tail ^ {16'h0000, word[15:8], 8'h00};
    end
    tail = tail ^ {24'h000000, word[7:0]};
  end

  // Hash sequencer: at most one multiply per cycle; it waits in F_PUSH until the queue takes the command
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    key_d   = key_q;
    rest_d  = rest_q;
    pos_d   = pos_q;
    h_d     = h_q;
    k_d     = k_q;
    b1_d    = b1_q;
    tag_d   = tag_q;
    unique case (state_q)
      F_IDLE: begin
        if (req_i.valid) begin
          op_d    = cfe_pkg::op_e'(req_i.operation);
          key_d   = req_i.key_bytes;
          rest_d  = len_sat;
          pos_d   = 1'b0;
          h_d     = cfe_pkg::HASH_SEED ^ 32'(len_sat);
          state_d = next_step(len_sat);
        end
      end
      F_K1: begin
        k_d     = cfe_pkg::hash_mul(word);
        state_d = F_K2;
      end
      F_K2: begin
        k_d     = cfe_pkg::hash_mul(k_q ^ (k_q >> 24));
        state_d = F_H;
      end
      F_H: begin
        h_d     = cfe_pkg::hash_mul(h_q) ^ k_q;
        rest_d  = rest_q - LW'(4);
        pos_d   = 1'b1;
        state_d = next_step(rest_q - LW'(4));
      end
      F_TAIL: begin
        h_d     = cfe_pkg::hash_mul(tail);
        state_d = F_FIN1;
      end
      F_FIN1: begin
        h_d     = cfe_pkg::hash_mul(h_q ^ (h_q >> 13));
        state_d = F_FIN2;
      end
      F_FIN2: begin
        // Zero marks an empty slot, so a zero fingerprint becomes one
        b1_d    = h_fin[8 +: BW];
        tag_d   = (h_fin[TW-1:0] == '0) ? TW'(1) : h_fin[TW-1:0];
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (cmd_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    rest_q <= rest_d;
    pos_q  <= pos_d;
    h_q    <= h_d;
    k_q    <= k_d;
    b1_q   <= b1_d;
    tag_q  <= tag_d;
  end

endmodule

`default_nettype wire

>>> hdl/cfe_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "cuckoo_filter_engine_macros.svh"

module cfe_back #(
  parameter int unsigned NUM_BUCKETS      = 1024,
  parameter int unsigned SLOTS_PER_BUCKET = 4,
  parameter int unsigned MAX_KICKS        = 500
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cmd_valid_i,
  output      logic                            cmd_ready_o,
  input  wire cfe_pkg::cmd_t                   cmd_i,
  input  wire logic [$clog2(NUM_BUCKETS)-1:0]  b1_i,
  input  wire logic [$clog2(NUM_BUCKETS)-1:0]  b2_i,
  cfe_rsp_if.source                            rsp_o
);

  localparam int unsigned BW    = $clog2(NUM_BUCKETS);
  localparam int unsigned TW    = cfe_pkg::TAG_W;
  localparam int unsigned SW    = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int unsigned ROW_W = SLOTS_PER_BUCKET * TW;
  localparam int unsigned KW    = $clog2(MAX_KICKS + 1);
  localparam int unsigned CW    = cfe_pkg::CNT_W;
  // Reciprocal for the slot pick, lfsr mod SLOTS_PER_BUCKET
  localparam int unsigned RSH   = 24;
  localparam logic [RSH:0] RECIP = (RSH + 1)'((1 << RSH) / SLOTS_PER_BUCKET);

  localparam logic [2:0] B_CLR  = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_RD   = 3'd2;
  localparam logic [2:0] B_EV   = 3'd3;
  localparam logic [2:0] B_ALT  = 3'd4;
  localparam logic [2:0] B_DONE = 3'd5;

  logic [2:0]        state_q, state_d;
  cfe_pkg::op_e      op_q, op_d;
  logic [TW-1:0]     tag_q, tag_d, ctag_q, ctag_d;
  logic [BW-1:0]     cur_q, cur_d, b2_q, b2_d;
  logic              phase_q, phase_d, chain_q, chain_d, vm_q, vm_d;
  logic [KW-1:0]     n_q, n_d;
  logic [BW-1:0]     vb_q, vb_d;
  logic [TW-1:0]     vfp_q, vfp_d;
  logic              vv_q, vv_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [15:0]       lfsr_q, lfsr_d;
  cfe_pkg::status_e  stat_q, stat_d;
  logic [BW-1:0]     clr_addr_q, clr_addr_d;
  logic              clr_op_q, clr_op_d;
  logic              ov_q;
  cfe_pkg::status_e  ostat_q;
  logic [CW-1:0]     ocnt_q;
  logic              ovic_q;
  logic              out_load;

  logic              ram_we;
  logic [BW-1:0]     ram_waddr, ram_raddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;

  logic [15:0]       q_q;
  logic [RSH+16:0]   recip_prod;
  logic [16:0]       rem_raw, rem;
  logic [SW-1:0]     kick_idx, empty_idx, match_idx;
  logic              has_empty, has_match, vmatch_in;
  logic [ROW_W-1:0]  row_ins, row_kick, row_del;
  logic [TW-1:0]     kick_old;
  logic [31:0]       mix;
  logic [KW-1:0]     n_inc;

  cfe_ram #(
    .WIDTH(ROW_W),
    .DEPTH(NUM_BUCKETS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Slot pick: quotient registered, remainder corrected once
  assign recip_prod = (RSH + 17)'(lfsr_q) * (RSH + 17)'(RECIP);
  assign rem_raw    = {1'b0, lfsr_q} - 17'(17'(q_q) * 17'(SLOTS_PER_BUCKET));
  assign rem        = (rem_raw >= 17'(SLOTS_PER_BUCKET)) ?
                      rem_raw - 17'(SLOTS_PER_BUCKET) : rem_raw;
  assign kick_idx   = rem[SW-1:0];

  always_ff @(posedge clk_i) begin
    q_q <= recip_prod[RSH +: 16];
  end

  assign mix   = cfe_pkg::tag_mix(ctag_q);
  assign n_inc = n_q + KW'(1);
  assign vmatch_in = vv_q && (cmd_i.tag == vfp_q) && (b1_i == vb_q || b2_i == vb_q);

  // Scan the bucket row for the first empty and first matching slot
  always_comb begin
    has_empty = 1'b0;
    has_match = 1'b0;
    empty_idx = '0;
    match_idx = '0;
    kick_old  = '0;
    row_ins   = ram_rdata;
    row_kick  = ram_rdata;
    row_del   = ram_rdata;
    for (int j = SLOTS_PER_BUCKET - 1; j >= 0; j--) begin
      if (ram_rdata[j*TW +: TW] == '0) begin
        has_empty = 1'b1;
        empty_idx = SW'(j);
      end
      if (ram_rdata[j*TW +: TW] == tag_q) begin
        has_match = 1'b1;
        match_idx = SW'(j);
      end
    end
    for (int j = 0; j < SLOTS_PER_BUCKET; j++) begin
      if (SW'(j) == empty_idx) begin
        row_ins[j*TW +: TW] = ctag_q;
      end
      if (SW'(j) == kick_idx) begin
        row_kick[j*TW +: TW] = ctag_q;
        kick_old             = ram_rdata[j*TW +: TW];
      end
      if (SW'(j) == match_idx) begin
        row_del[j*TW +: TW] = '0;
      end
    end
  end

  // Table engine sequencer
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    tag_d      = tag_q;
    ctag_d     = ctag_q;
    cur_d      = cur_q;
    b2_d       = b2_q;
    phase_d    = phase_q;
    chain_d    = chain_q;
    vm_d       = vm_q;
    n_d        = n_q;
    vb_d       = vb_q;
    vfp_d      = vfp_q;
    vv_d       = vv_q;
    cnt_d      = cnt_q;
    lfsr_d     = lfsr_q;
    stat_d     = stat_q;
    clr_addr_d = clr_addr_q;
    clr_op_d   = clr_op_q;
    ram_we     = 1'b0;
    ram_waddr  = cur_q;
    ram_wdata  = row_ins;
    ram_raddr  = cur_q;
    cmd_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      B_CLR: begin
        // Sweep one bucket row per cycle
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + BW'(1);
        if (clr_addr_q == BW'(NUM_BUCKETS - 1)) begin
          state_d = clr_op_q ? B_DONE : B_IDLE;
        end
      end
      B_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          op_d    = cmd_i.op;
          tag_d   = cmd_i.tag;
          ctag_d  = cmd_i.tag;
          cur_d   = b1_i;
          b2_d    = b2_i;
          phase_d = 1'b0;
          chain_d = 1'b0;
          n_d     = '0;
          vm_d    = vmatch_in;
          stat_d  = cfe_pkg::ST_OK;
          case (cmd_i.op)
            cfe_pkg::OP_ADD: begin
              if (vv_q) begin
                stat_d  = cfe_pkg::ST_NO_SPACE;
                state_d = B_DONE;
              end else begin
                chain_d = 1'b1;
                state_d = B_RD;
              end
            end
            cfe_pkg::OP_CLEAR: begin
              cnt_d      = '0;
              vv_d       = 1'b0;
              clr_addr_d = '0;
              clr_op_d   = 1'b1;
              state_d    = B_CLR;
            end
            default: state_d = B_RD;
          endcase
        end
      end
      B_RD: begin
        state_d = B_EV;
      end
      B_EV: begin
        if (chain_q) begin
          if (has_empty) begin
            ram_we  = 1'b1;
            ram_wdata = row_ins;
            cnt_d   = (cnt_q == cfe_pkg::CNT_MAX) ? cnt_q : cnt_q + CW'(1);
            stat_d  = cfe_pkg::ST_OK;
            state_d = B_DONE;
          end else begin
            // Evict on every step but the first, then move to the alternate
            if (n_q != '0) begin
              ram_we    = 1'b1;
              ram_wdata = row_kick;
              ctag_d    = kick_old;
              lfsr_d    = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? cfe_pkg::LFSR_TAPS : 16'h0000);
            end
            state_d = B_ALT;
          end
        end else if (op_q == cfe_pkg::OP_QUERY) begin
          if (has_match || (phase_q && vm_q)) begin
            stat_d  = cfe_pkg::ST_OK;
            state_d = B_DONE;
          end else if (!phase_q) begin
            phase_d = 1'b1;
            cur_d   = b2_q;
            state_d = B_RD;
          end else begin
            stat_d  = cfe_pkg::ST_NOT_FOUND;
            state_d = B_DONE;
          end
        end else begin
          if (has_match) begin
            ram_we    = 1'b1;
            ram_wdata = row_del;
            cnt_d     = (cnt_q == '0) ? cnt_q : cnt_q - CW'(1);
            stat_d    = cfe_pkg::ST_OK;
            if (vv_q) begin
              // Reinsert the parked fingerprint
              vv_d    = 1'b0;
              chain_d = 1'b1;
              cur_d   = vb_q;
              ctag_d  = vfp_q;
              n_d     = '0;
              state_d = B_RD;
            end else begin
              state_d = B_DONE;
            end
          end else if (!phase_q) begin
            phase_d = 1'b1;
            cur_d   = b2_q;
            state_d = B_RD;
          end else if (vm_q) begin
            vv_d    = 1'b0;
            stat_d  = cfe_pkg::ST_OK;
            state_d = B_DONE;
          end else begin
            stat_d  = cfe_pkg::ST_NOT_FOUND;
            state_d = B_DONE;
          end
        end
      end
      B_ALT: begin
        cur_d = cur_q ^ mix[BW-1:0];
        if (n_inc == KW'(MAX_KICKS)) begin
          // Out of kicks: park the fingerprint in hand
          vb_d    = cur_q ^ mix[BW-1:0];
          vfp_d   = ctag_q;
          vv_d    = 1'b1;
          stat_d  = cfe_pkg::ST_OK;
          state_d = B_DONE;
        end else begin
          n_d     = n_inc;
          state_d = B_RD;
        end
      end
      B_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          out_load = 1'b1;
          clr_op_d = 1'b0;
          state_d  = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_CLR;
      clr_addr_q <= '0;
      clr_op_q   <= 1'b0;
      vb_q       <= '0;
      vfp_q      <= '0;
      vv_q       <= 1'b0;
      cnt_q      <= '0;
      lfsr_q     <= cfe_pkg::LFSR_SEED;
      n_q        <= '0;
      chain_q    <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      clr_op_q   <= clr_op_d;
      vb_q       <= vb_d;
      vfp_q      <= vfp_d;
      vv_q       <= vv_d;
      cnt_q      <= cnt_d;
      lfsr_q     <= lfsr_d;
      n_q        <= n_d;
      chain_q    <= chain_d;
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    tag_q   <= tag_d;
    ctag_q  <= ctag_d;
    cur_q   <= cur_d;
    b2_q    <= b2_d;
    phase_q <= phase_d;
    vm_q    <= vm_d;
    stat_q  <= stat_d;
    if (out_load) begin
      ostat_q <= stat_q;
      ocnt_q  <= cnt_q;
      ovic_q  <= vv_q;
    end
  end

  // Hold the result until the receiver takes it
  assign rsp_o.valid         = ov_q;
  assign rsp_o.status        = ostat_q;
  assign rsp_o.item_count    = ocnt_q;
  assign rsp_o.victim_in_use = ovic_q;

  `CFE_ASSERT(a_chain_no_victim, clk_i, rst_ni, (state_q == B_EV && chain_q) |-> !vv_q, "insert chain running with victim parked")
  `CFE_ASSERT(a_kick_bound, clk_i, rst_ni, n_q < KW'(MAX_KICKS), "kick counter past limit")
  `CFE_ASSERT_NEVER(a_lfsr_zero, clk_i, rst_ni, lfsr_q == '0, "slot chooser stuck at zero")
  `CFE_ASSERT(a_no_result_overrun, clk_i, rst_ni, (ov_q && !rsp_o.ready) |=> (ov_q && $stable(ostat_q)), "held result overwritten")

endmodule

`default_nettype wire

>>> hdl/cuckoo_filter_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Cuckoo filter engine with a one-entry victim cache.
// Requests arrive on req_i (add, query, remove, clear plus a key of up to
// eight bytes); each produces exactly one response on rsp_o with a status,
// the number of stored fingerprints and the victim flag. Both channels
// transfer when valid and ready are high at a rising edge.
// A hash front end folds the key (one 32-bit multiply per cycle while it
// hashes; it waits while the queue is full). A two-entry queue feeds the
// table engine, which reads one bucket row per table access: a query or
// remove reads the first bucket and, if needed, the second; an add walks a
// chain of up to MAX_KICKS kicks. A clear sweeps the whole table.
// Steady rate for short requests is set by the slower of the hash unit and
// the table engine.
// After reset the engine sweeps the table; requests are hashed and queued
// meanwhile and executed once the sweep ends.
// A stalled receiver holds the response register; the engine finishes one
// more request and the front keeps hashing until the queue fills, then
// req_i.ready drops.
module cuckoo_filter_engine #(
  parameter int unsigned NUM_BUCKETS      = 1024,
  parameter int unsigned SLOTS_PER_BUCKET = 4,
  parameter int unsigned MAX_KICKS        = 500
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cfe_req_if.sink    req_i,
  cfe_rsp_if.source  rsp_o
);

  localparam int unsigned BW    = $clog2(NUM_BUCKETS);
  localparam int unsigned CMD_W = $bits(cfe_pkg::cmd_t);
  localparam int unsigned QW    = CMD_W + 2 * BW;

  logic          fr_valid, fr_ready, bk_valid, bk_ready;
  cfe_pkg::cmd_t fr_cmd, bk_cmd;
  logic [BW-1:0] fr_b1, fr_b2, bk_b1, bk_b2;
  logic [QW-1:0] q_in, q_out;

  cfe_front #(
    .BW(BW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cmd_valid_o(fr_valid),
    .cmd_ready_i(fr_ready),
    .cmd_o      (fr_cmd),
    .b1_o       (fr_b1),
    .b2_o       (fr_b2)
  );

  assign q_in = {fr_cmd, fr_b1, fr_b2};

  cfe_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(fr_ready),
    .push_data_i (q_in),
    .pop_valid_o (bk_valid),
    .pop_ready_i (bk_ready),
    .pop_data_o  (q_out)
  );

  assign bk_cmd = cfe_pkg::cmd_t'(q_out[QW-1 -: CMD_W]);
  assign bk_b1  = q_out[2*BW-1 -: BW];
  assign bk_b2  = q_out[BW-1:0];

  cfe_back #(
    .NUM_BUCKETS     (NUM_BUCKETS),
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET),
    .MAX_KICKS       (MAX_KICKS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(bk_valid),
    .cmd_ready_o(bk_ready),
    .cmd_i      (bk_cmd),
    .b1_i       (bk_b1),
    .b2_i       (bk_b2),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NB    = 1024;
  localparam int unsigned SLOTS = 4;
  localparam int unsigned KICKS = 500;
  localparam int unsigned N_RANDOM = 2000;

  // Expected response contents
  typedef struct {
    cfe_pkg::status_e          status;
    logic [cfe_pkg::CNT_W-1:0] count;
    logic                      victim;
  } filter_rsp_t;

  // Directed stimulus row; chk marks a typed-in expectation
  typedef struct {
    cfe_pkg::op_e op;
    logic [63:0]  key;
    logic [3:0]   len;
    bit           chk;
    filter_rsp_t  rsp;
  } probe_row_t;

  logic clk_i;
  logic rst_ni;

  cfe_req_if req_if ();
  cfe_rsp_if rsp_if ();

  cuckoo_filter_engine #(
    .NUM_BUCKETS     (NB),
    .SLOTS_PER_BUCKET(SLOTS),
    .MAX_KICKS       (KICKS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  // Shadow filter state
  logic [7:0]                shadow_table [NB*SLOTS];
  logic [9:0]                park_bucket;
  logic [7:0]                park_tag;
  logic                      park_valid;
  logic [cfe_pkg::CNT_W-1:0] shadow_count;
  logic [15:0]               slot_lfsr;

  filter_rsp_t pending_rsp [$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_idle_pct;
  logic [63:0] key_pool [16];

  // Clock: 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [31:0] murmur_hash(logic [63:0] key, int unsigned len);
    logic [31:0] h;
    logic [31:0] k;
    int unsigned pos;
    int unsigned rest;
    h    = cfe_pkg::HASH_SEED ^ len;
    pos  = 0;
    rest = len;
    while (rest >= 4) begin
      k = key[8*pos +: 32];
      k = k * cfe_pkg::HASH_MUL;
      k = k ^ (k >> 24);
      k = k * cfe_pkg::HASH_MUL;
      h = h * cfe_pkg::HASH_MUL;
      h = h ^ k;
      pos  += 4;
      rest -= 4;
    end
    if (rest > 0) begin
      if (rest >= 3) h = h ^ (32'(key[8*(pos+2) +: 8]) << 16);
      if (rest >= 2) h = h ^ (32'(key[8*(pos+1) +: 8]) << 8);
      h = h ^ 32'(key[8*pos +: 8]);
      h = h * cfe_pkg::HASH_MUL;
    end
    h = h ^ (h >> 13);
    h = h * cfe_pkg::HASH_MUL;
    h = h ^ (h >> 15);
    return h;
  endfunction

  function automatic logic [9:0] partner_bucket(logic [9:0] b, logic [7:0] t);
    logic [31:0] m;
    m = 32'(t) * cfe_pkg::HASH_MUL;
    return b ^ m[9:0];
  endfunction

  function automatic bit bucket_holds(logic [9:0] b, logic [7:0] t);
    for (int j = 0; j < SLOTS; j++)
      if (shadow_table[b*SLOTS+j] == t) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit bucket_drop(logic [9:0] b, logic [7:0] t);
    for (int j = 0; j < SLOTS; j++)
      if (shadow_table[b*SLOTS+j] == t) begin
        shadow_table[b*SLOTS+j] = '0;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  // Walk the displacement chain; park the tag in hand when kicks run out
  function automatic void cuckoo_insert(logic [9:0] b, logic [7:0] t);
    logic [9:0] cur;
    logic [7:0] tag;
    logic [7:0] evicted;
    int         slot;
    cur = b;
    tag = t;
    for (int n = 0; n < KICKS; n++) begin
      for (int j = 0; j < SLOTS; j++)
        if (shadow_table[cur*SLOTS+j] == 8'd0) begin
          shadow_table[cur*SLOTS+j] = tag;
          if (shadow_count < cfe_pkg::CNT_MAX) shadow_count++;
          return;
        end
      if (n > 0) begin
        slot    = slot_lfsr % SLOTS;
        evicted = shadow_table[cur*SLOTS+slot];
        shadow_table[cur*SLOTS+slot] = tag;
        slot_lfsr = slot_lfsr[0] ? ((slot_lfsr >> 1) ^ cfe_pkg::LFSR_TAPS) : (slot_lfsr >> 1);
        tag = evicted;
      end
      cur = partner_bucket(cur, tag);
    end
    park_bucket = cur;
    park_tag    = tag;
    park_valid  = 1'b1;
  endfunction

  function automatic filter_rsp_t filter_apply(cfe_pkg::op_e op, logic [63:0] key,
                                               logic [3:0] len_in);
    filter_rsp_t r;
    int unsigned len;
    logic [31:0] h;
    logic [9:0]  b1;
    logic [9:0]  b2;
    logic [7:0]  tag;
    bit          vhit;
    len = (len_in > cfe_pkg::MAX_KEY_BYTES) ? cfe_pkg::MAX_KEY_BYTES : len_in;
    h   = murmur_hash(key, len);
    b1  = h[17:8];
    tag = (h[7:0] == 8'd0) ? 8'd1 : h[7:0];
    b2  = partner_bucket(b1, tag);
    vhit = park_valid && tag == park_tag && (b1 == park_bucket || b2 == park_bucket);
    r.status = cfe_pkg::ST_OK;
    case (op)
      cfe_pkg::OP_ADD: begin
        if (park_valid) r.status = cfe_pkg::ST_NO_SPACE;
        else cuckoo_insert(b1, tag);
      end
      cfe_pkg::OP_QUERY: begin
        if (!(vhit || bucket_holds(b1, tag) || bucket_holds(b2, tag)))
          r.status = cfe_pkg::ST_NOT_FOUND;
      end
      cfe_pkg::OP_REMOVE: begin
        if (bucket_drop(b1, tag) || bucket_drop(b2, tag)) begin
          if (shadow_count > 0) shadow_count--;
          if (park_valid) begin
            park_valid = 1'b0;
            cuckoo_insert(park_bucket, park_tag);
          end
        end else if (vhit) begin
          park_valid = 1'b0;
        end else begin
          r.status = cfe_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        foreach (shadow_table[i]) shadow_table[i] = '0;
        shadow_count = '0;
        park_valid   = 1'b0;
      end
    endcase
    r.count  = shadow_count;
    r.victim = park_valid;
    return r;
  endfunction

  // Send one request and queue its expected response
  task automatic send_request(cfe_pkg::op_e op, logic [63:0] key, logic [3:0] len,
                              bit chk, filter_rsp_t typed);
    filter_rsp_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.key_bytes  <= key;
    req_if.key_length <= len;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    r = filter_apply(op, key, len);
    if (chk && (r.status != typed.status || r.count != typed.count ||
                r.victim != typed.victim)) begin
      if (mismatches < 10)
        $display("row op %0d key %h: exp st %0d cnt %0d vic %0d, pred st %0d cnt %0d vic %0d",
                 op, key, typed.status, typed.count, typed.victim,
                 r.status, r.count, r.victim);
      mismatches++;
    end
    pending_rsp.push_back(r);
  endtask

  // Receiver: random stalls, check each transfer against the oldest expectation
  always @(posedge clk_i) begin
    filter_rsp_t e;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_rsp.size() == 0) begin
          if (mismatches < 10) $display("response with nothing expected");
          mismatches++;
        end else begin
          e = pending_rsp.pop_front();
          if (rsp_if.status != e.status || rsp_if.item_count != e.count ||
              rsp_if.victim_in_use != e.victim) begin
            if (mismatches < 10)
              $display("exp st %0d cnt %0d vic %0d, got st %0d cnt %0d vic %0d",
                       e.status, e.count, e.victim, rsp_if.status,
                       rsp_if.item_count, rsp_if.victim_in_use);
            mismatches++;
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Run limit
  initial begin
    #100ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    probe_row_t   rows [$];
    filter_rsp_t  z;
    int           phase_len;
    int           pick;
    cfe_pkg::op_e op;
    logic [63:0]  key;
    logic [3:0]   len;
    int           wait_cycles;
    logic [63:0]  fill_key;

    mismatches    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_ni        = 1'b0;
    clk_i         = 1'b0;
    req_if.valid      = 1'b0;
    req_if.operation  = cfe_pkg::OP_ADD;
    req_if.key_bytes  = '0;
    req_if.key_length = '0;
    rsp_if.ready      = 1'b0;
    foreach (shadow_table[i]) shadow_table[i] = '0;
    park_bucket  = '0;
    park_tag     = '0;
    park_valid   = 1'b0;
    shadow_count = '0;
    slot_lfsr    = cfe_pkg::LFSR_SEED;
    fill_key     = 64'h0123_4567_89AB_CDEF;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: typed expectations where obvious
    z = '{cfe_pkg::ST_NOT_FOUND, 13'd0, 1'b0};
    rows.push_back('{cfe_pkg::OP_QUERY,  64'h0, 4'd0, 1'b1, z});
    rows.push_back('{cfe_pkg::OP_REMOVE, '1,    4'd8, 1'b1, z});
    z = '{cfe_pkg::ST_OK, 13'd1, 1'b0};
    rows.push_back('{cfe_pkg::OP_ADD,    '1,    4'd8, 1'b1, z});
    z = '{cfe_pkg::ST_OK, 13'd1, 1'b0};
    rows.push_back('{cfe_pkg::OP_QUERY,  '1,    4'd15, 1'b1, z});
    rows.push_back('{cfe_pkg::OP_ADD,    64'h0, 4'd0, 1'b0, z});
    rows.push_back('{cfe_pkg::OP_ADD,    64'h55, 4'd1, 1'b0, z});
    rows.push_back('{cfe_pkg::OP_ADD,    64'hAAAA, 4'd2, 1'b0, z});
    rows.push_back('{cfe_pkg::OP_ADD,    64'h123456, 4'd3, 1'b0, z});
    rows.push_back('{cfe_pkg::OP_ADD,    64'hDEADBEEF, 4'd4, 1'b0, z});
    rows.push_back('{cfe_pkg::OP_ADD,    64'h5555_5555_5555, 4'd7, 1'b0, z});
    rows.push_back('{cfe_pkg::OP_ADD,    64'hAAAA_AAAA_AAAA_AAAA, 4'd9, 1'b0, z});
    rows.push_back('{cfe_pkg::OP_QUERY,  64'hDEADBEEF, 4'd4, 1'b0, z});
    rows.push_back('{cfe_pkg::OP_REMOVE, 64'h55, 4'd1, 1'b0, z});
    rows.push_back('{cfe_pkg::OP_REMOVE, 64'h55, 4'd1, 1'b0, z});
    z = '{cfe_pkg::ST_OK, 13'd0, 1'b0};
    rows.push_back('{cfe_pkg::OP_CLEAR,  64'h0, 4'd0, 1'b1, z});
    z = '{cfe_pkg::ST_NOT_FOUND, 13'd0, 1'b0};
    rows.push_back('{cfe_pkg::OP_QUERY,  '1,    4'd8, 1'b1, z});
    foreach (rows[i]) send_request(rows[i].op, rows[i].key, rows[i].len, rows[i].chk, rows[i].rsp);
    // Repeat one key until its two buckets overflow and a victim is parked
    for (int i = 0; i < 12 && !park_valid; i++)
      send_request(cfe_pkg::OP_ADD, fill_key, 4'd8, 1'b0, z);
    z = '{cfe_pkg::ST_NO_SPACE, shadow_count, 1'b1};
    send_request(cfe_pkg::OP_ADD, 64'h0, 4'd0, park_valid, z);
    // Free one copy so the parked fingerprint is reinserted
    for (int i = 0; i < 4 && park_valid; i++)
      send_request(cfe_pkg::OP_REMOVE, fill_key, 4'd8, 1'b0, z);
    send_request(cfe_pkg::OP_CLEAR, 64'h0, 4'd0, 1'b0, z);

    // Random traffic in three phases with different idle rates; mostly a small key pool
    phase_len = N_RANDOM / 3;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 66 : 0;
      recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 36 : 0;
      for (int i = 0; i < phase_len; i++) begin
        pick = $urandom_range(99);
        op   = (pick < 45) ? cfe_pkg::OP_ADD : (pick < 70) ? cfe_pkg::OP_QUERY :
               (pick < 99) ? cfe_pkg::OP_REMOVE : cfe_pkg::OP_CLEAR;
        if ($urandom_range(3) != 0) begin
          key = key_pool[$urandom_range(15)];
          len = 4'd8;
        end else begin
          key = {$urandom, $urandom};
          len = 4'($urandom_range(15));
        end
        send_request(op, key, len, 1'b0, z);
      end
    end
    req_if.valid <= 1'b0;

    wait_cycles = 0;
    while (pending_rsp.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && pending_rsp.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/cfe_pkg.sv
hdl/cfe_if.sv
hdl/cfe_ram.sv
hdl/cfe_fifo.sv
hdl/cfe_front.sv
hdl/cfe_back.sv
hdl/cuckoo_filter_engine.sv
tb/tb.sv
